FILE: rtl/string_to_integer_parser_top_macros.svh
// assertion macros shared by the checker of the string parser
`ifndef STRING_TO_INTEGER_PARSER_TOP_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define STIP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define STIP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// implication that also holds while reset is applied
`define STIP_ASSERT_ALWAYS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/stip_pkg.sv
// types, constants and helpers shared by the string parser modules
package stip_pkg;

	localparam int CHAR_W       = 8;
	localparam int BASE_W       = 6;
	localparam int DIGIT_W      = 6;
	localparam int VALUE_OUT_W  = 32;
	localparam int LENGTH_OUT_W = 11;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [DIGIT_W-1:0] NO_DIGIT     = 6'd63;
	localparam logic [BASE_W-1:0]  BASE_DEFAULT = 6'd10;
	localparam logic [BASE_W-1:0]  BASE_MAX     = 6'd36;
	localparam logic [BASE_W-1:0]  BASE_AUTO    = 6'd0;
	localparam logic [BASE_W-1:0]  BASE_OCT     = 6'd8;
	localparam logic [BASE_W-1:0]  BASE_DEC     = 6'd10;
	localparam logic [BASE_W-1:0]  BASE_HEX     = 6'd16;

	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR        = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_PLUS      = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_MINUS     = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE      = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z   = 8'h5a;
	localparam logic [CHAR_W-1:0] CH_LOWER_A   = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z   = 8'h7a;
	localparam logic [CHAR_W-1:0] CH_UPPER_X   = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LOWER_X   = 8'h78;
	localparam logic [CHAR_W-1:0] UPPER_OFFSET = 8'd55;
	localparam logic [CHAR_W-1:0] LOWER_OFFSET = 8'd87;

	// one classified character as it waits in the queue
	typedef struct packed {
		logic                sos;
		logic [DIGIT_W-1:0]  digit;
		logic                is_space;
		logic                is_plus;
		logic                is_minus;
		logic                is_hex_mark;
		logic [BASE_W-1:0]   base;
	} char_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
		logic [DIGIT_W-1:0] d;
		d = NO_DIGIT;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = DIGIT_W'(c - CH_ZERO);
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			d = DIGIT_W'(c - UPPER_OFFSET);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			d = DIGIT_W'(c - LOWER_OFFSET);
		end
		return d;
	endfunction

endpackage

FILE: rtl/stip_ifs.sv
// valid/ready channel interfaces of the string parser
interface stip_char_if import stip_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              start_of_string;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, start_of_string, char_code, input ready);
	modport sink (input valid, start_of_string, char_code, output ready);
endinterface

interface stip_cfg_if import stip_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BASE_W-1:0] number_base;

	modport source (output valid, number_base, input ready);
	modport sink (input valid, number_base, output ready);
endinterface

interface stip_result_if import stip_pkg::*; ();
	logic                           valid;
	logic                           ready;
	logic signed [VALUE_OUT_W-1:0]  parsed_value;
	logic [LENGTH_OUT_W-1:0]        consumed_length;
	logic                           converted;
	logic                           overflowed;

	modport source (output valid, parsed_value, consumed_length, converted, overflowed,
		input ready);
	modport sink (input valid, parsed_value, consumed_length, converted, overflowed,
		output ready);
endinterface

FILE: rtl/stip_front.sv
// front end: base register, character classification and queue push
module stip_front import stip_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	stip_char_if.sink     chars,
	stip_cfg_if.sink      cfg,
	input  queue_status_t q_status,
	output logic          push,
	output char_entry_t   entry
);

	logic [BASE_W-1:0] base_q;
	logic [CHAR_W-1:0] c;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_DEFAULT;
		end else if (cfg.valid) begin
			base_q <= cfg.number_base;
		end
	end

	assign chars.ready = !q_status.full;
	assign push        = chars.valid && chars.ready;
	assign c           = chars.char_code;

	always_comb begin
		entry.sos         = chars.start_of_string;
		entry.digit       = digit_value(c);
		entry.is_space    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		entry.is_plus     = (c == CH_PLUS);
		entry.is_minus    = (c == CH_MINUS);
		entry.is_hex_mark = (c == CH_UPPER_X) || (c == CH_LOWER_X);
		// bases above 36 behave as 36
		entry.base        = (base_q > BASE_MAX) ? BASE_MAX : base_q;
	end

endmodule

FILE: rtl/stip_queue.sv
// short queue of classified characters between front and back end
module stip_queue import stip_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  char_entry_t   entry_in,
	input  logic          pop,
	output char_entry_t   entry_out,
	output queue_status_t status
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	char_entry_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign entry_out    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/stip_back.sv
// back end: parse state machine, digit accumulation and result register
module stip_back import stip_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_CHARS   = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  char_entry_t   entry,
	input  queue_status_t q_status,
	output logic          pop,
	stip_result_if.source results
);

	localparam int W    = VALUE_WIDTH;
	localparam int PW   = VALUE_WIDTH + 7;
	localparam int CW   = $clog2(MAX_CHARS + 1);
	localparam logic [W-1:0] POS_LIM  = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SIGN_MAG = {1'b1, {(W-1){1'b0}}};

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SPACE,
		PH_FIRST,
		PH_ZERO,
		PH_DIGITS
	} phase_t;

	phase_t            phase_q;
	logic              neg_q;
	logic              dseen_q;
	logic              ovf_q;
	logic [W-1:0]      acc_q;
	logic [BASE_W-1:0] base_q;
	logic [CW-1:0]     pos_q;

	logic                          out_valid_q;
	logic signed [VALUE_OUT_W-1:0] res_value_q;
	logic [LENGTH_OUT_W-1:0]       res_len_q;
	logic                          res_conv_q;
	logic                          res_ovf_q;

	phase_t            ph, nph;
	logic              nneg, ndseen, nov;
	logic [W-1:0]      nacc;
	logic [BASE_W-1:0] nbase, tbase;
	logic [CW-1:0]     npos;
	logic              first, zero_path, digits, count_up, emit;
	logic [PW-1:0]     prod, lim;
	logic [W-1:0]      fin_value;

	assign pop = !q_status.empty && (!out_valid_q || results.ready);

	always_comb begin
		// a string start clears the parse before this character is looked at
		ph     = entry.sos ? PH_SPACE : phase_q;
		nph    = ph;
		nneg   = entry.sos ? 1'b0 : neg_q;
		ndseen = entry.sos ? 1'b0 : dseen_q;
		nov    = entry.sos ? 1'b0 : ovf_q;
		nacc   = entry.sos ? '0 : acc_q;
		nbase  = entry.sos ? entry.base : base_q;
		npos   = entry.sos ? '0 : pos_q;
		first     = 1'b0;
		zero_path = 1'b0;
		digits    = 1'b0;
		count_up  = 1'b0;
		emit      = 1'b0;
		tbase     = BASE_DEC;
		prod      = '0;
		lim       = '0;

		case (ph)
			PH_SPACE: begin
				if (entry.is_space) begin
					count_up = 1'b1;
				end else if (entry.is_plus || entry.is_minus) begin
					nneg     = entry.is_minus;
					count_up = 1'b1;
					nph      = PH_FIRST;
				end else begin
					first = 1'b1;
				end
			end
			PH_FIRST:  first = 1'b1;
			PH_ZERO:   zero_path = 1'b1;
			PH_DIGITS: digits = 1'b1;
			default: ;
		endcase

		if (first) begin
			if ((nbase == BASE_AUTO || nbase == BASE_HEX) && entry.digit == '0) begin
				count_up = 1'b1;
				nph      = PH_ZERO;
			end else begin
				if (nbase == BASE_AUTO) nbase = BASE_DEC;
				nph    = PH_DIGITS;
				digits = 1'b1;
			end
		end

		if (zero_path) begin
			if (entry.is_hex_mark) begin
				nbase    = BASE_HEX;
				count_up = 1'b1;
				nph      = PH_DIGITS;
			end else begin
				// the leading zero alone already counts as a digit
				if (nbase == BASE_AUTO) nbase = BASE_OCT;
				ndseen = 1'b1;
				nacc   = '0;
				nph    = PH_DIGITS;
				digits = 1'b1;
			end
		end

		if (digits) begin
			tbase = (nbase == BASE_AUTO) ? BASE_DEC : nbase;
			if (entry.digit >= tbase) begin
				emit = 1'b1;
				nph  = PH_IDLE;
			end else begin
				prod = PW'(nacc) * PW'(tbase) + PW'(entry.digit);
				lim  = PW'(nneg ? SIGN_MAG : POS_LIM);
				if (nov || prod > lim) begin
					nov = 1'b1;
				end else begin
					nacc = prod[W-1:0];
				end
				ndseen   = 1'b1;
				count_up = 1'b1;
			end
		end

		if (count_up && npos < CW'(MAX_CHARS)) begin
			npos = npos + 1'b1;
		end

		if (!ndseen) begin
			fin_value = '0;
		end else if (nov) begin
			fin_value = nneg ? SIGN_MAG : POS_LIM;
		end else begin
			fin_value = nneg ? W'(-nacc) : nacc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			neg_q       <= 1'b0;
			dseen_q     <= 1'b0;
			ovf_q       <= 1'b0;
			acc_q       <= '0;
			base_q      <= BASE_DEFAULT;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			res_value_q <= '0;
			res_len_q   <= '0;
			res_conv_q  <= 1'b0;
			res_ovf_q   <= 1'b0;
		end else begin
			if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				phase_q <= nph;
				neg_q   <= nneg;
				dseen_q <= ndseen;
				ovf_q   <= nov;
				acc_q   <= nacc;
				base_q  <= nbase;
				pos_q   <= npos;
				if (emit) begin
					out_valid_q <= 1'b1;
					res_value_q <= VALUE_OUT_W'(signed'(fin_value));
					res_len_q   <= ndseen ? LENGTH_OUT_W'(npos) : '0;
					res_conv_q  <= ndseen;
					res_ovf_q   <= nov;
				end
			end
		end
	end

	assign results.valid           = out_valid_q;
	assign results.parsed_value    = res_value_q;
	assign results.consumed_length = res_len_q;
	assign results.converted       = res_conv_q;
	assign results.overflowed      = res_ovf_q;

endmodule

FILE: rtl/string_to_integer_parser_top.sv
// top level of the streaming string to integer parser
// a terminating character passes through the queue and then the result register before its result is valid
// throughput: one character per cycle while the result channel does not stall, set by the back end's
//   combinational multiply-add and limit compare on the accumulator
// reset: arst_n clears the queue, the parse state and the result register at once;
//   number_base comes out of reset as 10
module string_to_integer_parser_top import stip_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int MAX_CHARS   = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	stip_char_if.sink     chars,
	stip_cfg_if.sink      cfg,
	stip_result_if.source results
);

	// classified character handed from front end to queue
	char_entry_t   front_entry;
	// head of the queue as seen by the back end
	char_entry_t   back_entry;
	// queue fill status, full stalls the character channel
	queue_status_t q_status;
	logic          push;
	logic          pop;

	// front end: holds number_base, classifies each character transaction
	// and stamps it with the base that applies if it starts a string
	stip_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.cfg      (cfg),
		.q_status (q_status),
		.push     (push),
		.entry    (front_entry)
	);

	// two-entry queue lets the character side keep flowing while a result waits, until the queue fills
	stip_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.entry_in  (front_entry),
		.pop       (pop),
		.entry_out (back_entry),
		.status    (q_status)
	);

	// back end: one character per cycle through the parse state machine while the result channel does not stall;
	// the result register decouples it from the result channel
	stip_back #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_CHARS   (MAX_CHARS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.entry    (back_entry),
		.q_status (q_status),
		.pop      (pop),
		.results  (results)
	);

endmodule

FILE: rtl/stip_checker.sv
// port-level assertions for the string parser and their bind
`include "string_to_integer_parser_top_macros.svh"

module stip_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_value,
	input logic [10:0] res_len,
	input logic        res_conv,
	input logic        res_ovf
);

	localparam logic [VALUE_WIDTH-1:0] POS_LIM  = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] SIGN_MAG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [31:0] MAX_OUT = 32'(signed'(POS_LIM));
	localparam logic [31:0] MIN_OUT = 32'(signed'(SIGN_MAG));

	`STIP_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n, !res_valid, "result valid during reset")
	`STIP_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`STIP_ASSERT_NOW(a_empty_result, res_valid && !res_conv, res_value == 32'd0 && res_len == 11'd0 && !res_ovf, "nonzero fields without conversion")
	`STIP_ASSERT_NOW(a_saturated, res_valid && res_ovf, res_conv && (res_value == MAX_OUT || res_value == MIN_OUT), "overflow without saturated value")

endmodule

bind string_to_integer_parser_top stip_checker #(
	.VALUE_WIDTH (VALUE_WIDTH)
) u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_value (results.parsed_value),
	.res_len   (results.consumed_length),
	.res_conv  (results.converted),
	.res_ovf   (results.overflowed)
);
